/* hw/rtl/rlcl_pkg.sv */
// Shared types and constants for the run-length code-length table reader.
package rlcl_pkg;

   // Entries in one code-length table
   localparam logic [8:0] TableEntries = 9'd256;

   // Status codes of a result item
   typedef enum logic [1:0] {
      ST_RUN      = 2'd0,
      ST_DONE     = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_NODATA   = 2'd3
   } status_type;

   // Configuration register index and table count reset value
   localparam logic [1:0] RegTablesInStream = 2'd0;
   localparam logic [1:0] TablesReset       = 2'd3;

   // One result item
   typedef struct packed {
      logic [1:0]  table_number;
      logic [8:0]  run_start;
      logic [7:0]  run_count;
      logic [4:0]  code_length;
      status_type  status;
      logic [10:0] bytes_used;
      logic        last_of_item;
   } result_type;

   // Results of one parsed item, handed to the output queue
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

/* hw/rtl/rlcl_csr.sv */
// Configuration register file: table count register on an APB-style port.
module rlcl_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [1:0]  tables_in_stream
);

   logic [1:0] tables_ff;
   logic [1:0] tables_in;
   logic       wr_en;

   // Decode a completed write to the table count register
   assign wr_en = csr_psel && csr_penable && csr_pwrite
                  && (csr_paddr == {rlcl_pkg::RegTablesInStream});
   assign tables_in = wr_en ? csr_pwdata[1:0] : tables_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tables_ff <= rlcl_pkg::TablesReset;
      end else begin
         tables_ff <= tables_in;
      end
   end

   // Read back; unused addresses return zero
   assign csr_prdata = (csr_paddr == {rlcl_pkg::RegTablesInStream})
                       ? {30'd0, tables_ff} : 32'd0;
   assign csr_pready = 1'b1;
   assign tables_in_stream = tables_ff;

endmodule

/* hw/rtl/rlcl_parse.sv */
// Input register, parse state and per-item run decode.
module rlcl_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_stream_byte,
   input  logic                 req_first_byte,
   input  logic                 req_final_byte,
   input  logic [1:0]           tables_in_stream,
   input  logic                 space_ok,
   output rlcl_pkg::push_type   push
);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       first_ff, first_in;
   logic       final_ff, final_in;

   // Parse state
   logic        phase_ff, phase_in;
   logic [4:0]  pend_ff, pend_in;
   logic [8:0]  entry_ff, entry_in;
   logic [1:0]  table_ff, table_in;
   logic [10:0] bc_ff, bc_in;
   logic        fin_ff, fin_in;

   logic        fire;
   logic        accept;

   // Values seen by this item after an optional restart
   logic        c_phase;
   logic [4:0]  c_pend;
   logic [8:0]  c_entry;
   logic [1:0]  c_table;
   logic [10:0] c_bc;
   logic        c_fin;

   logic        have_run;
   logic [7:0]  repeat_v;
   logic [4:0]  len_v;
   logic [9:0]  sum;
   logic [1:0]  ntables;
   logic        last_table;
   logic [1:0]  n;
   rlcl_pkg::result_type r0, r1, rs;

   assign fire   = in_valid_ff && space_ok;
   assign accept = req_valid && !req_stall;
   assign req_stall = in_valid_ff && !space_ok;

   // Load the input register when it is free or being drained
   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      first_in    = first_ff;
      final_in    = final_ff;
      if (fire) begin
         in_valid_in = 1'b0;
      end
      if (accept) begin
         in_valid_in = 1'b1;
         byte_in     = req_stream_byte;
         first_in    = req_first_byte;
         final_in    = req_final_byte;
      end
   end

   // Decode one byte against the current state
   always_comb begin
      c_phase = first_ff ? 1'b0 : phase_ff;
      c_pend  = first_ff ? 5'd0 : pend_ff;
      c_entry = first_ff ? 9'd0 : entry_ff;
      c_table = first_ff ? 2'd0 : table_ff;
      c_bc    = first_ff ? 11'd0 : bc_ff;
      c_fin   = first_ff ? 1'b0 : fin_ff;

      phase_in = c_phase;
      pend_in  = c_pend;
      entry_in = c_entry;
      table_in = c_table;
      bc_in    = c_bc;
      fin_in   = c_fin;

      have_run = 1'b0;
      repeat_v = 8'd0;
      len_v    = 5'd0;
      sum      = 10'd0;
      ntables  = (tables_in_stream == 2'd0) ? 2'd1 : tables_in_stream;
      last_table = 1'b0;
      n  = 2'd0;
      r0 = '0;
      r1 = '0;
      rs = '0;

      if (!c_fin) begin
         // Saturate the byte count
         bc_in = (c_bc == 11'h7FF) ? c_bc : c_bc + 11'd1;

         if (!c_phase) begin
            repeat_v = {5'd0, byte_ff[7:5]};
            len_v    = byte_ff[4:0];
            if (byte_ff[7:5] == 3'd0) begin
               pend_in  = byte_ff[4:0];
               phase_in = 1'b1;
            end else begin
               have_run = 1'b1;
            end
         end else begin
            repeat_v = byte_ff;
            len_v    = c_pend;
            phase_in = 1'b0;
            have_run = 1'b1;
         end

         sum = {1'b0, c_entry} + {2'd0, repeat_v};
         rs.table_number = c_table;
         rs.run_start    = c_entry;
         rs.run_count    = repeat_v;
         rs.code_length  = len_v;
         rs.bytes_used   = bc_in;

         if (have_run) begin
            if (sum > {1'b0, rlcl_pkg::TableEntries}) begin
               // Reject the run and stop
               r0 = rs;
               r0.status = rlcl_pkg::ST_OVERFLOW;
               n = 2'd1;
               fin_in = 1'b1;
            end else begin
               r0 = rs;
               r0.status = rlcl_pkg::ST_RUN;
               n = 2'd1;
               entry_in = sum[8:0];
               if (sum == {1'b0, rlcl_pkg::TableEntries}) begin
                  last_table = ({1'b0, c_table} + 3'd1) >= {1'b0, ntables};
                  if (last_table) begin
                     r1.table_number = c_table;
                     r1.run_start    = rlcl_pkg::TableEntries;
                     r1.run_count    = 8'd0;
                     r1.code_length  = 5'd0;
                     r1.status       = rlcl_pkg::ST_DONE;
                     r1.bytes_used   = bc_in;
                     n = 2'd2;
                     fin_in = 1'b1;
                  end else begin
                     table_in = c_table + 2'd1;
                     entry_in = 9'd0;
                  end
               end
            end
         end

         // Flag data ending before the tables are complete
         if (!fin_in && final_ff) begin
            rs = '0;
            rs.table_number = table_in;
            rs.run_start    = entry_in;
            rs.status       = rlcl_pkg::ST_NODATA;
            rs.bytes_used   = bc_in;
            if (n == 2'd0) begin
               r0 = rs;
               n  = 2'd1;
            end else begin
               r1 = rs;
               n  = 2'd2;
            end
            fin_in = 1'b1;
         end

         // Mark the final result of the item
         if (n == 2'd1) begin
            r0.last_of_item = 1'b1;
         end else if (n == 2'd2) begin
            r1.last_of_item = 1'b1;
         end
      end
   end

   assign push.count = fire ? n : 2'd0;
   assign push.res0  = r0;
   assign push.res1  = r1;

   // Input register and parse state; state advances when the item is parsed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= 1'b0;
         pend_ff     <= 5'd0;
         entry_ff    <= 9'd0;
         table_ff    <= 2'd0;
         bc_ff       <= 11'd0;
         fin_ff      <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            pend_ff  <= pend_in;
            entry_ff <= entry_in;
            table_ff <= table_in;
            bc_ff    <= bc_in;
            fin_ff   <= fin_in;
         end
      end
      byte_ff  <= byte_in;
      first_ff <= first_in;
      final_ff <= final_in;
   end

   // An active table never holds a full entry count
   assert property (@(posedge clock) disable iff (reset)
      !fin_ff |-> (entry_ff < rlcl_pkg::TableEntries))
      else $error("entry index reached table size while parsing");

   // An overflow result always stops parsing
   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0 && push.res0.status == rlcl_pkg::ST_OVERFLOW) |=> fin_ff)
      else $error("overflow did not finish the stream");

   // A finished stream emits nothing until restarted
   assert property (@(posedge clock) disable iff (reset)
      (fire && fin_ff && !first_ff) |-> (push.count == 2'd0))
      else $error("result emitted after finish");

endmodule

/* hw/rtl/rlcl_outq.sv */
// Four-entry result queue: takes up to two results a cycle while it has room, sends one unless stalled.
module rlcl_outq (
   input  logic                       clock,
   input  logic                       reset,
   input  rlcl_pkg::push_type         push,
   output logic                       space_ok,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rlcl_pkg::result_type       rsp_res
);

   rlcl_pkg::result_type slot_ff [4];
   logic [1:0] wr_ff, wr_in;
   logic [1:0] rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] wr_next;

   assign rsp_valid = (cnt_ff != 3'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_res   = slot_ff[rd_ff];
   // Room for a full pair after this cycle's send
   assign space_ok  = (cnt_ff <= 3'd2) || (cnt_ff == 3'd3 && pop);
   assign wr_next   = wr_ff + 2'd1;

   // Advance pointers and occupancy
   always_comb begin
      wr_in  = wr_ff + push.count;
      rd_in  = pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {1'b0, push.count} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store results in order
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_next] <= push.res1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd4)
      else $error("result queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> space_ok)
      else $error("push without room");

   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (cnt_ff == $past(cnt_ff) + {1'b0, $past(push.count)}
                                    - {2'd0, $past(pop)}))
      else $error("queue count out of step");

endmodule

/* hw/rtl/run_length_code_length_table_reader.sv */
// Top level of the run-length code-length table reader.
//
// Header bytes enter on the req_ channel (valid/stall), one item per byte.
// req_first_byte restarts parsing at table 0; req_final_byte marks the last
// byte of available data. Each byte yields zero, one or two result items on
// the rsp_ channel: a run (start, count, length) or an overflow status, then
// possibly an all-done or out-of-data status. last_of_item flags the final
// result of a byte. The csr_ port holds the table count (reset value 3);
// the user must write it only while the block is idle; this is not enforced.
//
// An accepted byte is held in the input register, parsed, and its results
// are written into the result queue, whose occupancy drives rsp_valid.
// Throughput: one byte per cycle while each byte gives at most one result
// and rsp_stall is low; a byte that gives two results puts both into the
// four-entry result queue, which sends them one at a time.
// Reset clears all parse state and the queue; no clearing pass is needed.
// When rsp_stall is held, the queue fills and req_stall rises once it has no
// room for another pair of results; nothing is dropped.
module run_length_code_length_table_reader (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_first_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_table_number,
   output logic [8:0]  rsp_run_start,
   output logic [7:0]  rsp_run_count,
   output logic [4:0]  rsp_code_length,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_bytes_used,
   output logic        rsp_last_of_item,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [1:0]            tables_in_stream;
   logic                  space_ok;
   rlcl_pkg::push_type    push;
   rlcl_pkg::result_type  res;

   rlcl_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .tables_in_stream (tables_in_stream)
   );

   rlcl_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_stream_byte  (req_stream_byte),
      .req_first_byte   (req_first_byte),
      .req_final_byte   (req_final_byte),
      .tables_in_stream (tables_in_stream),
      .space_ok         (space_ok),
      .push             (push)
   );

   rlcl_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_res   (res)
   );

   // Unpack the result item onto its ports
   assign rsp_table_number = res.table_number;
   assign rsp_run_start    = res.run_start;
   assign rsp_run_count    = res.run_count;
   assign rsp_code_length  = res.code_length;
   assign rsp_status       = res.status;
   assign rsp_bytes_used   = res.bytes_used;
   assign rsp_last_of_item = res.last_of_item;

endmodule
